// ===== src/bcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcfp_pkg
// Shared constants, types and character classes for the bracket frame parser.
// ----------------------------------------------------------------------------
package bcfp_pkg;

  localparam int unsigned POS_W = 5;

  localparam logic [7:0] CH_LBR      = 8'h5B;
  localparam logic [7:0] CH_RBR      = 8'h5D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam logic [POS_W-1:0] SLOT_START = 5'd0;
  localparam logic [POS_W-1:0] SLOT_CMD   = 5'd1;
  localparam logic [POS_W-1:0] SLOT_LEN   = 5'd2;
  localparam logic [POS_W-1:0] SLOT_DATA  = 5'd3;

  typedef enum logic [1:0] {
    WR_START = 2'd0,
    WR_CMD   = 2'd1,
    WR_LEN   = 2'd2,
    WR_POS   = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    len_load;
    logic    pos_inc;
    logic    emit_start;
  } dp_cmd_t;

  typedef struct packed {
    logic is_lbr;
    logic is_rbr;
    logic is_upper;
    logic is_dec;
    logic is_hex;
    logic len_zero;
    logic hex_last;
    logic emit_done;
  } dp_status_t;

  function automatic logic is_upper_ch(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_dec_ch(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex_ch(logic [7:0] c);
    return is_dec_ch(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

// ===== src/bcfp_datapath.sv =====
// ----------------------------------------------------------------------------
// bcfp_datapath
// Frame store, write pointer, hex counter and the output read sequencer.
// ----------------------------------------------------------------------------
module bcfp_datapath
  import bcfp_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);

  logic [7:0]       mem [FRAME_DEPTH];
  logic [POS_W-1:0] wpos_q, wpos_d;
  logic [POS_W-1:0] hex_left_q, hex_left_d;
  logic [POS_W-1:0] rptr_q, rptr_d;
  logic             emit_q, emit_d;
  logic             valid_q, valid_d;
  logic             last_q;
  logic [7:0]       rdata_q;
  logic [POS_W-1:0] waddr;
  logic             rd_issue;
  logic             rd_final;
  logic [3:0]       nib;

  assign nib = 4'(ch_i & NIBBLE_MASK);

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_START: waddr = SLOT_START;
      WR_CMD:   waddr = SLOT_CMD;
      WR_LEN:   waddr = SLOT_LEN;
      WR_POS:   waddr = wpos_q;
      default:  waddr = wpos_q;
    endcase
  end

  assign rd_issue = emit_q && (!valid_q || out_ready_i);
  assign rd_final = rptr_q == wpos_q;

  always_comb begin
    wpos_d     = wpos_q;
    hex_left_d = hex_left_q;
    if (cmd_i.len_load) begin
      wpos_d     = SLOT_DATA;
      hex_left_d = {nib, 1'b0};
    end else if (cmd_i.pos_inc) begin
      wpos_d     = wpos_q + POS_W'(1);
      hex_left_d = hex_left_q - POS_W'(1);
    end
  end

  always_comb begin
    rptr_d  = rptr_q;
    emit_d  = emit_q;
    valid_d = valid_q;
    if (cmd_i.emit_start) begin
      rptr_d = '0;
      emit_d = 1'b1;
    end else if (rd_issue) begin
      rptr_d = rptr_q + POS_W'(1);
      if (rd_final) emit_d = 1'b0;
    end
    if (rd_issue) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      hex_left_q <= '0;
      rptr_q     <= '0;
      emit_q     <= 1'b0;
      valid_q    <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      wpos_q     <= wpos_d;
      hex_left_q <= hex_left_d;
      rptr_q     <= rptr_d;
      emit_q     <= emit_d;
      valid_q    <= valid_d;
      if (rd_issue) last_q <= rd_final;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[AW'(waddr)] <= ch_i;
    if (rd_issue) rdata_q <= mem[AW'(rptr_q)];
  end

  assign status_o.is_lbr    = ch_i == CH_LBR;
  assign status_o.is_rbr    = ch_i == CH_RBR;
  assign status_o.is_upper  = is_upper_ch(ch_i);
  assign status_o.is_dec    = is_dec_ch(ch_i);
  assign status_o.is_hex    = is_hex_ch(ch_i);
  assign status_o.len_zero  = nib == 4'd0;
  assign status_o.hex_last  = hex_left_q == POS_W'(1);
  assign status_o.emit_done = rd_issue && rd_final;

  assign out_valid_o = valid_q;
  assign out_char_o  = rdata_q;
  assign out_last_o  = last_q;

endmodule

// ===== src/bcfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcfp_ctrl
// Parse state machine: steers the datapath from the character classes.
// ----------------------------------------------------------------------------
module bcfp_ctrl
  import bcfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_HUNT = 6'b000001,
    S_CMD  = 6'b000010,
    S_LEN  = 6'b000100,
    S_DATA = 6'b001000,
    S_END  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = state_q != S_EMIT;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{wr_en: 1'b0, wr_sel: WR_POS, len_load: 1'b0,
                pos_inc: 1'b0, emit_start: 1'b0};
    if (state_q == S_EMIT) begin
      if (status_i.emit_done) state_d = S_HUNT;
    end else if (accept) begin
      if (status_i.is_lbr) begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_START;
        state_d      = S_CMD;
      end else begin
        unique case (state_q)
          S_CMD: begin
            if (status_i.is_upper) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WR_CMD;
              state_d      = S_LEN;
            end else begin
              state_d = S_HUNT;
            end
          end
          S_LEN: begin
            if (status_i.is_dec) begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_sel   = WR_LEN;
              cmd_o.len_load = 1'b1;
              state_d        = status_i.len_zero ? S_END : S_DATA;
            end else begin
              state_d = S_HUNT;
            end
          end
          S_DATA: begin
            if (status_i.is_hex) begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.pos_inc = 1'b1;
              state_d       = status_i.hex_last ? S_END : S_DATA;
            end else begin
              state_d = S_HUNT;
            end
          end
          S_END: begin
            if (status_i.is_rbr) begin
              cmd_o.wr_en      = 1'b1;
              cmd_o.emit_start = 1'b1;
              state_d          = S_EMIT;
            end else begin
              state_d = S_HUNT;
            end
          end
          default: state_d = S_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/bracket_command_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// bracket_command_frame_parser_top
// Recognises "[", command letter, length digit d, 2*d hex digits, "]" and
// replays each complete frame one character per beat.
// ----------------------------------------------------------------------------
// One character is taken per cycle while parsing. After the closing bracket
// the input stalls while the frame (4 + 2*d beats, up to 22) is read back out
// of the frame store, one beat per cycle at best, set by the single store
// read port; the input reopens in the cycle after the last store read, while
// the final beat may still sit in the output register. tlast marks the "]".
module bracket_command_frame_parser_top
  import bcfp_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] frame_char
  output logic       m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bcfp_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== src/bcfp_checker.sv =====
// ----------------------------------------------------------------------------
// bcfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module bcfp_checker
  import bcfp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic first_q;

  // next output beat opens a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      first_q <= m_axis_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_last_is_rbr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CH_RBR)
    else $error("last beat is not a closing bracket");

  a_first_is_lbr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && first_q |-> m_axis_tdata == CH_LBR && !m_axis_tlast)
    else $error("frame does not open with a bracket");

  a_stall_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid) && $past(s_axis_tdata) == CH_RBR)
    else $error("input stalled without a closing bracket");

endmodule

bind bracket_command_frame_parser_top bcfp_checker u_bcfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
